// File: rtl/assert_macros.svh
// Assertion macros for the port-level checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mvc_pkg.sv
// Shared constants and command codes for the minimum vertex cut core.
// No dependencies.
`timescale 1ns / 1ps

package mvc_pkg;
	localparam int NODES       = 64;
	localparam int QUEUE_DEPTH = 128;
	localparam int VERTS       = 2 * NODES;
	localparam int NW          = $clog2(NODES);
	localparam int VW          = $clog2(VERTS);
	localparam int QAW         = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(NODES + 1);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LINK  = 2'd1;
	localparam logic [1:0] CMD_SOLVE = 2'd2;

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [6:0] NODE_COUNT_RESET = 7'd64;
endpackage

// File: rtl/mvc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mvc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/min_vertex_cut_max_flow_core.sv
// Minimum vertex cut core: link loads, clear and max-flow solve over RAM-held state.
// Sequence: clear completes in ST_IDLE; link writes ST_LNK_WA then ST_LNK_WB; solve skips the search
// for trivial cases, else runs one BFS per augmenting path, offering one vertex per cycle in ST_SF_SCAN.
// Throughput: one transaction at a time; input stalls until the result is taken.
// Reset: asynchronous active low; graph empty, node_count 64, no result pending.
// Depends on mvc_pkg and mvc_ram.
`timescale 1ns / 1ps

module min_vertex_cut_max_flow_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [5:0]  node_a,
	input  logic [5:0]  node_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  cut_size,
	output logic        no_cut,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NODES = mvc_pkg::NODES;
	localparam int VERTS = mvc_pkg::VERTS;
	localparam int NW    = mvc_pkg::NW;
	localparam int VW    = mvc_pkg::VW;
	localparam int QAW   = mvc_pkg::QAW;
	localparam int CW    = mvc_pkg::CW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LNK_WA, ST_LNK_WB, ST_SV_CHK, ST_SF_INIT, ST_SF_DEQ,
		ST_SF_QWAIT, ST_SF_RWAIT, ST_SF_SCAN, ST_PP_RD, ST_PP_WAIT, ST_PP_CF, ST_OUT
	} state_t;

	state_t             state_q;
	logic [6:0]         node_count_q;
	logic [NODES-1:0]   lm_vld_q, cf_vld_q, busy_q, bits_q;
	logic [VERTS-1:0]   reached_q;
	logic [NW-1:0]      src_q, dst_q, row_q, bit_q;
	logic [QAW:0]       head_q, tail_q;
	logic [VW-1:0]      x_q, y_q, p_q;
	logic [VW:0]        steps_q;
	logic [CW-1:0]      rounds_q, flow_q;
	logic               pre_q, post_q, set_q, lm_rv_q, cf_rv_q;
	logic               out_valid_q, no_cut_q;
	logic [5:0]         cut_q;

	logic [CW-1:0]      n_act;
	logic [NODES-1:0]   mask;
	logic               lm_we, cf_we, vis_en, vis_ok;
	logic [NW-1:0]      lm_waddr, lm_raddr, cf_waddr, cf_raddr;
	logic [NODES-1:0]   lm_wdata, cf_wdata, lm_rdata, cf_rdata, lm_row, cf_row;
	logic [VW-1:0]      vis_to, q_rdata, par_rdata, start_v;
	logic [VW-1:0]      x_node_v, partner;
	logic [NW-1:0]      xv, qv, low;
	logic               x_exit, q_exit, accept, cfg_wr;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cut_size = cut_q;
	assign no_cut = no_cut_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == mvc_pkg::REG_NODE_COUNT) ? {25'b0, node_count_q} : 32'b0;

	always_comb begin
		if (node_count_q == 7'd0) begin
			n_act = CW'(1);
		end else if (node_count_q > 7'(NODES)) begin
			n_act = CW'(NODES);
		end else begin
			n_act = CW'(node_count_q);
		end
		for (int i = 0; i < NODES; i++) begin
			mask[i] = (CW'(i) < n_act);
		end
	end

	assign start_v  = VW'(NODES) + VW'(src_q);
	assign x_exit   = (x_q >= VW'(NODES));
	assign xv       = x_exit ? NW'(x_q - VW'(NODES)) : NW'(x_q);
	assign partner  = x_exit ? VW'(xv) : VW'(NODES) + VW'(xv);
	assign q_exit   = (q_rdata >= VW'(NODES));
	assign qv       = q_exit ? NW'(q_rdata - VW'(NODES)) : NW'(q_rdata);
	assign lm_row   = lm_rv_q ? lm_rdata : '0;
	assign cf_row   = cf_rv_q ? cf_rdata : '0;

	always_comb begin
		low = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (bits_q[i]) begin
				low = NW'(i);
			end
		end
	end

	assign x_node_v = x_exit ? VW'(low) : VW'(NODES) + VW'(low);

	always_comb begin
		vis_en = 1'b0;
		vis_to = start_v;
		if (state_q == ST_SF_INIT) begin
			vis_en = 1'b1;
		end else if (state_q == ST_SF_SCAN) begin
			if (pre_q) begin
				vis_en = 1'b1;
				vis_to = partner;
			end else if (bits_q != '0) begin
				vis_en = 1'b1;
				vis_to = x_node_v;
			end else if (post_q) begin
				vis_en = 1'b1;
				vis_to = partner;
			end
		end
		vis_ok = vis_en && (state_q == ST_SF_INIT ||
			(!reached_q[vis_to] && tail_q < (QAW+1)'(mvc_pkg::QUEUE_DEPTH)));
	end

	always_comb begin
		lm_we = 1'b0;
		lm_waddr = src_q;
		lm_wdata = lm_row;
		lm_raddr = node_a;
		cf_we = 1'b0;
		cf_waddr = row_q;
		cf_wdata = set_q ? (cf_row | (NODES'(1) << bit_q)) : (cf_row & ~(NODES'(1) << bit_q));
		cf_raddr = qv;
		case (state_q)
			ST_LNK_WA: begin
				lm_we = 1'b1;
				lm_wdata = lm_row | (NODES'(1) << dst_q);
				lm_raddr = dst_q;
			end
			ST_LNK_WB: begin
				lm_we = 1'b1;
				lm_waddr = dst_q;
				lm_wdata = lm_row | (NODES'(1) << src_q);
			end
			ST_SF_QWAIT: begin
				lm_raddr = qv;
			end
			ST_PP_WAIT: begin
				cf_raddr = (par_rdata < VW'(NODES)) ? NW'(par_rdata) : NW'(y_q);
			end
			ST_PP_CF: begin
				cf_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mvc_ram #(.W(NODES), .D(NODES)) u_link_map (
		.clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
		.raddr(lm_raddr), .rdata(lm_rdata)
	);

	mvc_ram #(.W(NODES), .D(NODES)) u_flow_col (
		.clk(clk), .we(cf_we), .waddr(cf_waddr), .wdata(cf_wdata),
		.raddr(cf_raddr), .rdata(cf_rdata)
	);

	mvc_ram #(.W(VW), .D(mvc_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(vis_ok), .waddr(state_q == ST_SF_INIT ? '0 : tail_q[QAW-1:0]),
		.wdata(vis_to), .raddr(head_q[QAW-1:0]), .rdata(q_rdata)
	);

	mvc_ram #(.W(VW), .D(VERTS)) u_parent (
		.clk(clk), .we(vis_ok), .waddr(vis_to), .wdata(x_q),
		.raddr(y_q), .rdata(par_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= mvc_pkg::NODE_COUNT_RESET;
			lm_vld_q     <= '0;
			cf_vld_q     <= '0;
			busy_q       <= '0;
			reached_q    <= '0;
			out_valid_q  <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			rounds_q     <= '0;
			flow_q       <= '0;
			pre_q        <= 1'b0;
			post_q       <= 1'b0;
			lm_rv_q      <= 1'b0;
			cf_rv_q      <= 1'b0;
		end else begin
			lm_rv_q <= lm_vld_q[lm_raddr];
			cf_rv_q <= cf_vld_q[cf_raddr];
			if (cfg_wr && paddr[2] == mvc_pkg::REG_NODE_COUNT) begin
				node_count_q <= pwdata[6:0];
			end
			if (vis_ok) begin
				if (state_q == ST_SF_INIT) begin
					reached_q <= VERTS'(1) << vis_to;
					tail_q <= (QAW+1)'(1);
				end else begin
					reached_q[vis_to] <= 1'b1;
					tail_q <= tail_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					src_q <= node_a;
					dst_q <= node_b;
					if (accept) begin
						case (cmd)
							mvc_pkg::CMD_CLEAR: begin
								lm_vld_q <= '0;
							end
							mvc_pkg::CMD_LINK: begin
								if (CW'(node_a) < n_act && CW'(node_b) < n_act &&
									node_a != node_b) begin
									state_q <= ST_LNK_WA;
								end
							end
							mvc_pkg::CMD_SOLVE: begin
								cf_vld_q <= '0;
								busy_q   <= '0;
								flow_q   <= '0;
								rounds_q <= '0;
								if (node_a == node_b) begin
									cut_q <= '0;
									no_cut_q <= 1'b1;
									out_valid_q <= 1'b1;
									state_q <= ST_OUT;
								end else if (CW'(node_a) >= n_act || CW'(node_b) >= n_act) begin
									cut_q <= '0;
									no_cut_q <= 1'b0;
									out_valid_q <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_SV_CHK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LNK_WA: begin
					lm_vld_q[src_q] <= 1'b1;
					state_q <= ST_LNK_WB;
				end
				ST_LNK_WB: begin
					lm_vld_q[dst_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SV_CHK: begin
					if (lm_row[dst_q]) begin
						cut_q <= '0;
						no_cut_q <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						x_q <= start_v;
						state_q <= ST_SF_INIT;
					end
				end
				ST_SF_INIT: begin
					head_q <= '0;
					state_q <= ST_SF_DEQ;
				end
				ST_SF_DEQ: begin
					if (reached_q[VW'(dst_q)]) begin
						y_q <= VW'(dst_q);
						steps_q <= '0;
						state_q <= ST_PP_RD;
					end else if (head_q < tail_q) begin
						head_q <= head_q + 1'b1;
						state_q <= ST_SF_QWAIT;
					end else begin
						cut_q <= 6'(flow_q);
						no_cut_q <= 1'b0;
						out_valid_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_SF_QWAIT: begin
					x_q <= q_rdata;
					if (CW'(qv) >= n_act) begin
						state_q <= ST_SF_DEQ;
					end else begin
						state_q <= ST_SF_RWAIT;
					end
				end
				ST_SF_RWAIT: begin
					bits_q <= (x_exit ? lm_row : cf_row) & mask;
					pre_q <= !x_exit && !busy_q[xv];
					post_q <= x_exit && busy_q[xv];
					state_q <= ST_SF_SCAN;
				end
				ST_SF_SCAN: begin
					if (pre_q) begin
						pre_q <= 1'b0;
					end else if (bits_q != '0) begin
						bits_q <= bits_q & (bits_q - 1'b1);
					end else if (post_q) begin
						post_q <= 1'b0;
					end else begin
						state_q <= ST_SF_DEQ;
					end
				end
				ST_PP_RD: begin
					if (y_q == start_v || steps_q >= (VW+1)'(VERTS)) begin
						flow_q <= flow_q + 1'b1;
						rounds_q <= rounds_q + 1'b1;
						if (rounds_q + 1'b1 == CW'(NODES)) begin
							cut_q <= 6'(flow_q + 1'b1);
							no_cut_q <= 1'b0;
							out_valid_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							x_q <= start_v;
							state_q <= ST_SF_INIT;
						end
					end else begin
						state_q <= ST_PP_WAIT;
					end
				end
				ST_PP_WAIT: begin
					p_q <= par_rdata;
					if (par_rdata < VW'(NODES)) begin
						if (y_q == VW'(NODES) + par_rdata) begin
							busy_q[NW'(par_rdata)] <= 1'b1;
							y_q <= par_rdata;
							steps_q <= steps_q + 1'b1;
							state_q <= ST_PP_RD;
						end else if (y_q >= VW'(NODES)) begin
							row_q <= NW'(par_rdata);
							bit_q <= NW'(y_q - VW'(NODES));
							set_q <= 1'b0;
							state_q <= ST_PP_CF;
						end else begin
							y_q <= par_rdata;
							steps_q <= steps_q + 1'b1;
							state_q <= ST_PP_RD;
						end
					end else if (y_q < VW'(NODES)) begin
						if (NW'(par_rdata - VW'(NODES)) == NW'(y_q)) begin
							busy_q[NW'(y_q)] <= 1'b0;
							y_q <= par_rdata;
							steps_q <= steps_q + 1'b1;
							state_q <= ST_PP_RD;
						end else begin
							row_q <= NW'(y_q);
							bit_q <= NW'(par_rdata - VW'(NODES));
							set_q <= 1'b1;
							state_q <= ST_PP_CF;
						end
					end else begin
						y_q <= par_rdata;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_PP_RD;
					end
				end
				ST_PP_CF: begin
					cf_vld_q[row_q] <= 1'b1;
					y_q <= p_q;
					steps_q <= steps_q + 1'b1;
					state_q <= ST_PP_RD;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// File: rtl/mvc_checker.sv
// Port-level checker for the minimum vertex cut core, bound into the core module.
// Depends on assert_macros.svh and mvc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] cmd,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] cut_size,
	input logic       no_cut
);
	logic       flag_out, out_wait, other_acc;
	logic [6:0] res;

	assign flag_out  = out_valid && no_cut;
	assign out_wait  = out_valid && out_stall;
	assign res       = {cut_size, no_cut};
	assign other_acc = in_valid && !in_stall && cmd != mvc_pkg::CMD_SOLVE && !out_valid;

	`ASSERT_CLK(a_nocut_zero, clk, arst_n, !flag_out || cut_size == 6'd0, "no_cut with cut")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(res), "result changed")
	`ASSERT_NEXT(a_no_spurious, clk, arst_n, other_acc, !out_valid, "result without solve")
endmodule

bind min_vertex_cut_max_flow_core mvc_checker u_mvc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
	.out_valid(out_valid), .out_stall(out_stall), .cut_size(cut_size), .no_cut(no_cut)
);

// File: verif/min_vertex_cut_max_flow_checker.sv
// Checker for the minimum vertex cut core: watches the command and result channels,
// predicts each cut from its own graph model, and counts mismatches. Depends on mvc_pkg.
`timescale 1ns / 1ps

module min_vertex_cut_max_flow_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [5:0] cut_size,
	input  logic       no_cut,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output int         errors,
	output int         pending
);
	typedef struct packed {
		logic [5:0] size;
		logic       none;
	} cut_t;

	logic [6:0]                node_count;
	logic [mvc_pkg::NODES-1:0] links [mvc_pkg::NODES];
	logic [mvc_pkg::NODES-1:0] flow [mvc_pkg::NODES];
	logic [mvc_pkg::NODES-1:0] busy;
	logic [mvc_pkg::VERTS-1:0] seen;
	logic [7:0]                parent [mvc_pkg::VERTS];
	logic [7:0]                bfs_q [mvc_pkg::QUEUE_DEPTH];
	int                        q_head, q_tail;
	cut_t                      cut_q [$];

	assign pending = cut_q.size();

	function automatic int active_nodes();
		if (node_count < 1) return 1;
		if (node_count > mvc_pkg::NODES) return mvc_pkg::NODES;
		return node_count;
	endfunction

	function automatic void reach(int to, int from);
		if (to >= mvc_pkg::VERTS || seen[to] || q_tail >= mvc_pkg::QUEUE_DEPTH) return;
		seen[to] = 1'b1;
		parent[to] = from[7:0];
		bfs_q[q_tail] = to[7:0];
		q_tail++;
	endfunction

	function automatic bit search(int src, int dst, int n);
		int x, v;
		seen = '0;
		q_head = 0;
		q_tail = 0;
		reach(src, src);
		while (q_head < q_tail && !seen[dst]) begin
			x = bfs_q[q_head];
			q_head++;
			if (x < mvc_pkg::NODES) begin
				if (x >= n) continue;
				if (!busy[x]) reach(mvc_pkg::NODES + x, x);
				for (int u = 0; u < n; u++)
					if (flow[u][x]) reach(mvc_pkg::NODES + u, x);
			end else begin
				v = x - mvc_pkg::NODES;
				if (v >= n) continue;
				for (int u = 0; u < n; u++)
					if (links[v][u]) reach(u, x);
				if (busy[v]) reach(v, x);
			end
		end
		return seen[dst];
	endfunction

	function automatic void augment(int src, int dst);
		int y, p, steps;
		y = dst;
		steps = 0;
		while (y != src && steps < mvc_pkg::VERTS) begin
			p = parent[y];
			if (p < mvc_pkg::NODES) begin
				if (y == p + mvc_pkg::NODES) busy[p] = 1'b1;
				else if (y >= mvc_pkg::NODES) flow[y - mvc_pkg::NODES][p] = 1'b0;
			end else if (y < mvc_pkg::NODES) begin
				if (p - mvc_pkg::NODES == y) busy[y] = 1'b0;
				else flow[p - mvc_pkg::NODES][y] = 1'b1;
			end
			y = p;
			steps++;
		end
	endfunction

	function automatic cut_t solve_cut(int a, int b);
		int n, total;
		cut_t r;
		n = active_nodes();
		for (int i = 0; i < mvc_pkg::NODES; i++) flow[i] = '0;
		busy = '0;
		r = '0;
		if (a == b) begin
			r.none = 1'b1;
			return r;
		end
		if (a >= n || b >= n) return r;
		if (links[a][b]) begin
			r.none = 1'b1;
			return r;
		end
		total = 0;
		for (int k = 0; k < mvc_pkg::NODES; k++) begin
			if (!search(mvc_pkg::NODES + a, b, n)) break;
			augment(mvc_pkg::NODES + a, b);
			total++;
		end
		r.size = total[5:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cut_t want;
		int n;
		if (!arst_n) begin
			node_count = mvc_pkg::NODE_COUNT_RESET;
			for (int i = 0; i < mvc_pkg::NODES; i++) links[i] = '0;
			cut_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == mvc_pkg::REG_NODE_COUNT)
				node_count = pwdata[6:0];
			if (out_valid && !out_stall) begin
				if (cut_q.size() == 0) begin
					$display("%0t: unexpected result cut_size=%0d no_cut=%0d",
						$time, cut_size, no_cut);
					errors++;
				end else begin
					want = cut_q.pop_front();
					if (want.size !== cut_size || want.none !== no_cut) begin
						$display("%0t: mismatch expected cut_size=%0d no_cut=%0d, actual %0d %0d",
							$time, want.size, want.none, cut_size, no_cut);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				n = active_nodes();
				case (cmd)
					mvc_pkg::CMD_CLEAR: for (int i = 0; i < mvc_pkg::NODES; i++) links[i] = '0;
					mvc_pkg::CMD_LINK: if (node_a < n && node_b < n && node_a != node_b) begin
						links[node_a][node_b] = 1'b1;
						links[node_b][node_a] = 1'b1;
					end
					mvc_pkg::CMD_SOLVE: cut_q.insert(cut_q.size(), solve_cut(node_a, node_b));
					default: ;
				endcase
			end
		end
	end
endmodule

// File: verif/min_vertex_cut_max_flow_core_tb.sv
// Testbench top for the minimum vertex cut core: drives graph loads, solves and
// node_count writes under varied idling, and reports the checker's verdict.
`timescale 1ns / 1ps

module min_vertex_cut_max_flow_core_tb;
	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] cmd = '0;
	logic [5:0] node_a = '0, node_b = '0, cut_size;
	logic no_cut, pready;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	int errors, pending, idle_cycles, send_idle, recv_stall;

	always #5 clk = ~clk;

	min_vertex_cut_max_flow_core dut (.*);
	min_vertex_cut_max_flow_checker chk (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

	task automatic send(input logic [1:0] c, input int a, input int b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		node_a <= a[5:0];
		node_b <= b[5:0];
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_count(input int v);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		psel <= 1;
		paddr <= {mvc_pkg::REG_NODE_COUNT, 2'b00};
		pwrite <= 1;
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic random_graph(input int n, input int links);
		send(mvc_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63));
		repeat (links) send(mvc_pkg::CMD_LINK, $urandom_range(n - 1), $urandom_range(n - 1));
	endtask

	initial begin
		int n, lim;
		send_idle = 0;
		recv_stall = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send(mvc_pkg::CMD_SOLVE, 5, 5);
		send(mvc_pkg::CMD_SOLVE, 0, 63);
		send(mvc_pkg::CMD_LINK, 0, 63);
		send(mvc_pkg::CMD_SOLVE, 63, 0);
		send(mvc_pkg::CMD_LINK, 3, 3);
		send(2'd3, 63, 63);
		send(mvc_pkg::CMD_LINK, 0, 1);
		send(mvc_pkg::CMD_LINK, 1, 2);
		send(mvc_pkg::CMD_LINK, 0, 4);
		send(mvc_pkg::CMD_LINK, 4, 2);
		send(mvc_pkg::CMD_SOLVE, 0, 2);
		send(mvc_pkg::CMD_CLEAR, 0, 0);
		send(mvc_pkg::CMD_SOLVE, 0, 2);
		write_count(0);
		send(mvc_pkg::CMD_LINK, 0, 1);
		send(mvc_pkg::CMD_SOLVE, 0, 1);
		write_count(4);
		send(mvc_pkg::CMD_LINK, 0, 5);
		send(mvc_pkg::CMD_LINK, 1, 2);
		send(mvc_pkg::CMD_SOLVE, 0, 5);
		send(mvc_pkg::CMD_SOLVE, 1, 3);
		write_count(127);
		send(mvc_pkg::CMD_SOLVE, 1, 2);
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				3: begin send_idle = 28; recv_stall = 28; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			case (ph)
				0: n = 8;
				3: n = 1;
				5: n = 64;
				6: n = 2;
				default: n = $urandom_range(3, 16);
			endcase
			write_count(n);
			lim = (n > 12) ? 12 : n;
			for (int g = 0; g < 12; g++) begin
				random_graph(lim, $urandom_range(2 * lim));
				repeat (6) begin
					if ($urandom_range(9) == 0)
						send(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
					else
						send(mvc_pkg::CMD_SOLVE, $urandom_range(lim - 1),
							$urandom_range(lim - 1));
				end
			end
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		recv_stall = 0;
		repeat (200) @(negedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
